// ===== hdl/lspd_pkg.sv =====
// shared constants for the line sensor pd steering block
// field widths, register indexes, register reset values, parameter defaults
// no dependencies
package lspd_pkg;

   // payload and register widths
   localparam int SAMPLE_W   = 12;
   localparam int THR_W      = 12;
   localparam int SPEED_W    = 15;
   localparam int GAIN_W     = 16;
   localparam int MARGIN_W   = 4;
   localparam int DRIVE_W    = 16;
   localparam int OFFSET_W   = 12;
   localparam int COUNT_W    = 4;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // parameter defaults
   localparam int SENSOR_COUNT_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 12;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LINE_THR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_THR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPIN_SPEED = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MARGIN     = 3'd6;

   // register reset values
   localparam logic [THR_W-1:0]    LINE_THR_RST   = 12'd780;
   localparam logic [THR_W-1:0]    FWD_THR_RST    = 12'd1300;
   localparam logic [SPEED_W-1:0]  BASE_SPEED_RST = 15'd10486;
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 16'd2949;
   localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 16'd1966;
   localparam logic [SPEED_W-1:0]  SPIN_SPEED_RST = 15'd13763;
   localparam logic [MARGIN_W-1:0] MARGIN_RST     = 4'd4;

   typedef logic signed [DRIVE_W-1:0] drive_type;

endpackage

// ===== hdl/line_sensor_pd_steering_top.sv =====
// line sensor pd steering, top level
// accumulates one scan of line sensor samples and produces motor drives
// depends on lspd_pkg
//
// throughput: one sample request per cycle inside a scan; the last sample of a
//   scan holds off requests until the final stage hands its result to the result
//   register, through the bit-serial divider (one quotient bit a cycle) and the
//   one shared multiplier used twice; a scan with no side hits skips the divider
// result path: divider, prop multiply, derivative multiply, final stage, result register
// reset: synchronous active high, clears the scan state, previous offset,
//   result valid and loads the register defaults
module line_sensor_pd_steering_top #(
   parameter int SENSOR_COUNT = lspd_pkg::SENSOR_COUNT_DEF,
   parameter int SAMPLE_BITS  = lspd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample requests
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lspd_pkg::SAMPLE_W-1:0]         req_sample,
   input  logic                                  req_scan_start,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lspd_pkg::DRIVE_W-1:0]   rsp_left_drive,
   output logic signed [lspd_pkg::DRIVE_W-1:0]   rsp_right_drive,
   output logic                                  rsp_line_kind,
   output logic signed [lspd_pkg::OFFSET_W-1:0]  rsp_line_offset,
   output logic                                  rsp_forward_seen,
   output logic [lspd_pkg::COUNT_W-1:0]          rsp_hit_count,
   // configuration writes
   input  logic                                  csr_wr_en,
   input  logic [lspd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lspd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lspd_pkg::*;

   // sensor geometry: forward sensor just left of center, center pair weighs 0
   localparam int IDX_W        = $clog2(SENSOR_COUNT);
   localparam int FWD_IDX      = SENSOR_COUNT / 2 - 1;
   localparam int RIGHT_CENTRE = SENSOR_COUNT / 2;
   localparam int LAST_IDX     = SENSOR_COUNT - 1;
   localparam int LEFT_MAX     = SENSOR_COUNT / 2 - 1;
   localparam int RIGHT_MAX    = SENSOR_COUNT - 1 - SENSOR_COUNT / 2;
   localparam int SIDE_W       = $clog2(RIGHT_MAX + 1);
   localparam int CNT_W        = $clog2(LEFT_MAX + RIGHT_MAX + 1);
   localparam int SUM_MAX      = RIGHT_MAX * (RIGHT_MAX + 1) / 2;
   localparam int SUM_W        = $clog2(SUM_MAX + 1) + 1;
   localparam int WT_W         = IDX_W + 1;
   localparam int CMP_W        = SIDE_W + MARGIN_W;

   // divider: |sum| * 256 divided by the hit count, one quotient bit a cycle
   localparam int NUM_W        = SUM_W - 1 + 8;
   localparam int DCNT_W       = $clog2(NUM_W + 1);
   localparam int OFF_W        = $clog2(RIGHT_MAX * 256 + 1) + 1;

   // pd arithmetic widths
   localparam int PROD_W       = GAIN_W + 1 + OFF_W + 1;
   localparam int ACC_W        = PROD_W + 1;
   localparam int SAT_W        = ACC_W + 1;

   localparam int MASK_BITS    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - MASK_BITS);

   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32767);
   localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(32768);
   localparam logic [ACC_W-1:0]        ROUND_HALF = ACC_W'(256);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_MUL_P = 3'd2;
   localparam logic [2:0] S_MUL_D = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   // configuration registers
   logic [THR_W-1:0]    line_thr_ff, line_thr_in;
   logic [THR_W-1:0]    fwd_thr_ff, fwd_thr_in;
   logic [SPEED_W-1:0]  base_ff, base_in;
   logic [GAIN_W-1:0]   kp_ff, kp_in;
   logic [GAIN_W-1:0]   kd_ff, kd_in;
   logic [SPEED_W-1:0]  spin_ff, spin_in;
   logic [MARGIN_W-1:0] margin_ff, margin_in;

   // sequencer and scan accumulators
   logic [2:0]              state_ff, state_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SIDE_W-1:0]       left_ff, left_in;
   logic [SIDE_W-1:0]       right_ff, right_in;
   logic                    fwd_ff, fwd_in;

   // finished scan, held while the result is worked out
   logic [SIDE_W-1:0]       wleft_ff, wleft_in;
   logic [SIDE_W-1:0]       wright_ff, wright_in;
   logic                    wfwd_ff, wfwd_in;
   logic                    neg_ff, neg_in;

   // divider
   logic [NUM_W-1:0]        dq_ff, dq_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        den_ff, den_in;
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;

   // pd datapath
   logic signed [OFF_W-1:0] offset_ff, offset_in;
   logic signed [OFF_W-1:0] prev_ff, prev_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   drive_type               rsp_left_ff, rsp_left_in;
   drive_type               rsp_right_ff, rsp_right_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic signed [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic                    rsp_fwd_ff, rsp_fwd_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // combinational helpers
   logic                    accept;
   logic [SAMPLE_W-1:0]     smp;
   logic [IDX_W-1:0]        idx_eff;
   logic signed [SUM_W-1:0] sum_base;
   logic [SIDE_W-1:0]       left_base, right_base;
   logic                    fwd_base;
   logic                    side_hit;
   logic                    is_left, is_right, is_fwd;
   logic signed [WT_W-1:0]  wt_left, wt_right;
   logic signed [SUM_W-1:0] sum_next;
   logic [SIDE_W-1:0]       left_next, right_next;
   logic                    fwd_next;
   logic signed [SUM_W-1:0] sum_abs;
   logic [CNT_W-1:0]        cnt_next;
   logic [CNT_W:0]          trial;
   logic                    qbit;
   logic signed [OFF_W-1:0] off_mag, off_calc;
   logic signed [GAIN_W:0]  mul_a;
   logic signed [OFF_W:0]   mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0] corr_sh;
   logic signed [SAT_W-1:0] corr_x, base_x, pd_l, pd_r;
   drive_type               sat_l, sat_r, spin_pos;
   logic [SIDE_W-1:0]       side_diff;
   logic                    curve;
   logic                    fin_load;
   logic [CNT_W-1:0]        wcnt;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // ---------------------------------------------------------------
   // sample accumulation: a scan start drops any partial scan
   // ---------------------------------------------------------------
   assign smp        = req_sample & SAMPLE_MASK;
   assign idx_eff    = req_scan_start ? '0 : scan_idx_ff;
   assign sum_base   = req_scan_start ? '0 : sum_ff;
   assign left_base  = req_scan_start ? '0 : left_ff;
   assign right_base = req_scan_start ? '0 : right_ff;
   assign fwd_base   = req_scan_start ? 1'b0 : fwd_ff;

   assign side_hit   = (smp >= line_thr_ff);
   assign is_fwd     = (idx_eff == IDX_W'(FWD_IDX));
   assign is_left    = (idx_eff <  IDX_W'(FWD_IDX));
   assign is_right   = (idx_eff >  IDX_W'(RIGHT_CENTRE));

   // left sensors weigh idx - FWD_IDX (negative), right ones idx - RIGHT_CENTRE
   assign wt_left    = WT_W'(idx_eff) - WT_W'(FWD_IDX);
   assign wt_right   = WT_W'(idx_eff) - WT_W'(RIGHT_CENTRE);

   always_comb begin
      sum_next   = sum_base;
      left_next  = left_base;
      right_next = right_base;
      fwd_next   = fwd_base;
      if (is_fwd) begin
         fwd_next = (smp >= fwd_thr_ff);
      end else if (side_hit && is_left) begin
         sum_next  = sum_base + SUM_W'(wt_left);
         left_next = left_base + SIDE_W'(1);
      end else if (side_hit && is_right) begin
         sum_next   = sum_base + SUM_W'(wt_right);
         right_next = right_base + SIDE_W'(1);
      end
   end

   assign sum_abs  = sum_next[SUM_W-1] ? -sum_next : sum_next;
   assign cnt_next = CNT_W'(left_next) + CNT_W'(right_next);

   // ---------------------------------------------------------------
   // restoring divide step: remainder stays below the divisor
   // ---------------------------------------------------------------
   assign trial = {rem_ff, dq_ff[NUM_W-1]};
   assign qbit  = (trial >= {1'b0, den_ff});

   // quotient magnitude fits in OFF_W-1 bits, truncation toward zero via sign
   assign off_mag  = OFF_W'(dq_ff);
   assign off_calc = neg_ff ? -off_mag : off_mag;

   // ---------------------------------------------------------------
   // shared multiplier: prop term first, derivative term second
   // ---------------------------------------------------------------
   always_comb begin
      if (state_ff == S_MUL_D) begin
         mul_a = signed'({1'b0, kd_ff});
         mul_b = (OFF_W+1)'(offset_ff) - (OFF_W+1)'(prev_ff);
      end else begin
         mul_a = signed'({1'b0, kp_ff});
         mul_b = (OFF_W+1)'(off_calc);
      end
   end
   assign prod = mul_a * mul_b;

   // ---------------------------------------------------------------
   // final stage: q24 -> q15 rounded to nearest (half added, then floor shift), drive and saturate
   // ---------------------------------------------------------------
   assign corr_sh = acc_ff >>> 9;
   assign corr_x  = SAT_W'(corr_sh);
   assign base_x  = signed'(SAT_W'(base_ff));
   assign pd_l    = base_x + corr_x;
   assign pd_r    = base_x - corr_x;

   assign sat_l = (pd_l > SAT_HI) ? DRIVE_W'(SAT_HI) :
                  (pd_l < SAT_LO) ? DRIVE_W'(SAT_LO) : DRIVE_W'(pd_l);
   assign sat_r = (pd_r > SAT_HI) ? DRIVE_W'(SAT_HI) :
                  (pd_r < SAT_LO) ? DRIVE_W'(SAT_LO) : DRIVE_W'(pd_r);

   assign spin_pos  = signed'({1'b0, spin_ff});
   assign side_diff = (wleft_ff >= wright_ff) ? (wleft_ff - wright_ff)
                                              : (wright_ff - wleft_ff);
   // curve when the side counts differ by the margin or more
   assign curve     = (CMP_W'(side_diff) >= CMP_W'(margin_ff));
   assign wcnt      = CNT_W'(wleft_ff) + CNT_W'(wright_ff);

   // the result register takes the scan once it is free or being drained
   assign fin_load  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   // ---------------------------------------------------------------
   // configuration decode
   // ---------------------------------------------------------------
   always_comb begin
      line_thr_in = line_thr_ff;
      fwd_thr_in  = fwd_thr_ff;
      base_in     = base_ff;
      kp_in       = kp_ff;
      kd_in       = kd_ff;
      spin_in     = spin_ff;
      margin_in   = margin_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_LINE_THR:   line_thr_in = csr_wdata[THR_W-1:0];
            REG_FWD_THR:    fwd_thr_in  = csr_wdata[THR_W-1:0];
            REG_BASE_SPEED: base_in     = csr_wdata[SPEED_W-1:0];
            REG_PROP_GAIN:  kp_in       = csr_wdata[GAIN_W-1:0];
            REG_DERIV_GAIN: kd_in       = csr_wdata[GAIN_W-1:0];
            REG_SPIN_SPEED: spin_in     = csr_wdata[SPEED_W-1:0];
            REG_MARGIN:     margin_in   = csr_wdata[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      sum_in      = sum_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      fwd_in      = fwd_ff;
      wleft_in    = wleft_ff;
      wright_in   = wright_ff;
      wfwd_in     = wfwd_ff;
      neg_in      = neg_ff;
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      dcnt_in     = dcnt_ff;
      offset_in   = offset_ff;
      prev_in     = prev_ff;
      acc_in      = acc_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (idx_eff == IDX_W'(LAST_IDX)) begin
                  // scan complete: hand it to the datapath, clear for the next one
                  scan_idx_in = '0;
                  sum_in      = '0;
                  left_in     = '0;
                  right_in    = '0;
                  fwd_in      = 1'b0;
                  wleft_in    = left_next;
                  wright_in   = right_next;
                  wfwd_in     = fwd_next;
                  neg_in      = sum_next[SUM_W-1];
                  den_in      = cnt_next;
                  rem_in      = '0;
                  dcnt_in     = '0;
                  if (cnt_next == '0) begin
                     // no side hits: offset is zero, skip the divide
                     dq_in    = '0;
                     state_in = S_MUL_P;
                  end else begin
                     dq_in    = {sum_abs[SUM_W-2:0], 8'd0};
                     state_in = S_DIV;
                  end
               end else begin
                  scan_idx_in = idx_eff + IDX_W'(1);
                  sum_in      = sum_next;
                  left_in     = left_next;
                  right_in    = right_next;
                  fwd_in      = fwd_next;
               end
            end
         end
         S_DIV: begin
            rem_in  = qbit ? CNT_W'(trial - {1'b0, den_ff}) : CNT_W'(trial);
            dq_in   = {dq_ff[NUM_W-2:0], qbit};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(NUM_W - 1)) begin
               state_in = S_MUL_P;
            end
         end
         S_MUL_P: begin
            // prop term plus the rounding half, before the floor shift
            offset_in = off_calc;
            acc_in    = ACC_W'(prod) + ROUND_HALF;
            state_in  = S_MUL_D;
         end
         S_MUL_D: begin
            acc_in   = acc_ff + ACC_W'(prod);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (fin_load) begin
               // previous offset moves on every scan, curve or not
               prev_in  = offset_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_fwd_in    = rsp_fwd_ff;
      rsp_count_in  = rsp_count_ff;
      if (fin_load) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = curve;
         rsp_offset_in = OFFSET_W'(offset_ff);
         rsp_fwd_in    = wfwd_ff;
         rsp_count_in  = COUNT_W'(wcnt);
         if (curve) begin
            // spin in place toward the line
            if (!offset_ff[OFF_W-1] && (offset_ff != '0)) begin
               rsp_left_in  = spin_pos;
               rsp_right_in = -spin_pos;
            end else begin
               rsp_left_in  = -spin_pos;
               rsp_right_in = spin_pos;
            end
         end else begin
            rsp_left_in  = sat_l;
            rsp_right_in = sat_r;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_drive   = rsp_left_ff;
   assign rsp_right_drive  = rsp_right_ff;
   assign rsp_line_kind    = rsp_kind_ff;
   assign rsp_line_offset  = rsp_offset_ff;
   assign rsp_forward_seen = rsp_fwd_ff;
   assign rsp_hit_count    = rsp_count_ff;

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         line_thr_ff  <= LINE_THR_RST;
         fwd_thr_ff   <= FWD_THR_RST;
         base_ff      <= BASE_SPEED_RST;
         kp_ff        <= PROP_GAIN_RST;
         kd_ff        <= DERIV_GAIN_RST;
         spin_ff      <= SPIN_SPEED_RST;
         margin_ff    <= MARGIN_RST;
         state_ff     <= S_IDLE;
         scan_idx_ff  <= '0;
         sum_ff       <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         fwd_ff       <= 1'b0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_thr_ff  <= line_thr_in;
         fwd_thr_ff   <= fwd_thr_in;
         base_ff      <= base_in;
         kp_ff        <= kp_in;
         kd_ff        <= kd_in;
         spin_ff      <= spin_in;
         margin_ff    <= margin_in;
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         sum_ff       <= sum_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         fwd_ff       <= fwd_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      wleft_ff      <= wleft_in;
      wright_ff     <= wright_in;
      wfwd_ff       <= wfwd_in;
      neg_ff        <= neg_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      dcnt_ff       <= dcnt_in;
      offset_ff     <= offset_in;
      acc_ff        <= acc_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_fwd_ff    <= rsp_fwd_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // the divider never runs past its last quotient bit
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dcnt_ff < DCNT_W'(NUM_W)))
      else $error("divider step count out of range");

   // a new result only comes out of the final stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("result raised outside the final stage");

   // a curve result spins the motors in opposite directions at equal speed
   a_spin_mirror: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff) |-> (rsp_left_ff == -rsp_right_ff))
      else $error("curve drives not mirrored");

   // side hit counters stay within the number of side sensors
   a_hits_range: assert property (@(posedge clock) disable iff (reset)
      (CMP_W'(left_ff) <= CMP_W'(LEFT_MAX)) && (CMP_W'(right_ff) <= CMP_W'(RIGHT_MAX)))
      else $error("side hit counter overflow");

endmodule
